// ===== rtl/sxb_pkg.sv =====
// Shared constants, codes and types of the sprite XOR blitter.
// No dependencies; every other file but sxb_ram takes names from here by scope.
package sxb_pkg;

   // Screen size; both are powers of two so reductions are bit masks.
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int X_BITS        = $clog2(SCREEN_WIDTH);
   localparam int Y_BITS        = $clog2(SCREEN_HEIGHT);

   localparam int LINE_BITS     = 64;
   localparam int LINE_IDX_BITS = $clog2(LINE_BITS);

   localparam int OFF_BITS      = 4;
   localparam int ROW_BITS      = 8;
   localparam int LINE_SEL_BITS = 5;
   localparam int COORD_BITS    = 8;

   localparam int YS_BITS       = ((Y_BITS > OFF_BITS) ? Y_BITS : OFF_BITS) + 1;

   localparam int PIX_STEPS     = ROW_BITS;
   localparam int STEP_BITS     = $clog2(PIX_STEPS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(PIX_STEPS - 1);

   localparam logic CMD_DRAW  = 1'b0;
   localparam logic CMD_READ  = 1'b1;
   localparam logic KIND_DRAW = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic [X_BITS-1:0]    x0;
      logic [STEP_BITS-1:0] step;
      logic                 bit_on;
      logic                 clip;
   } pix_ctl_type;

endpackage

// ===== rtl/sxb_if.sv =====
// Handshake channels of the sprite XOR blitter: request, response, control.
// Depends on sxb_pkg for field widths.
interface sxb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [sxb_pkg::COORD_BITS-1:0]       start_x;
   logic [sxb_pkg::COORD_BITS-1:0]       start_y;
   logic [sxb_pkg::OFF_BITS-1:0]         row_offset;
   logic [sxb_pkg::ROW_BITS-1:0]         row_bits;
   logic                                 last_row;
   logic [sxb_pkg::LINE_SEL_BITS-1:0]    display_row;

   modport source (output valid, cmd, start_x, start_y, row_offset, row_bits, last_row,
                   display_row, input ready);
   modport sink   (input valid, cmd, start_x, start_y, row_offset, row_bits, last_row,
                   display_row, output ready);
endinterface

interface sxb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic                           collision;
   logic [sxb_pkg::LINE_BITS-1:0]  row_pixels;

   modport source (output valid, kind, collision, row_pixels, input ready);
   modport sink   (input valid, kind, collision, row_pixels, output ready);
endinterface

interface sxb_csr_if;
   logic valid;
   logic ready;
   logic clip_mode;

   modport source (output valid, clip_mode, input ready);
   modport sink   (input valid, clip_mode, output ready);
endinterface

// ===== rtl/sprite_xor_blitter_core.sv =====
// Top level of the sprite XOR blitter: sequencer, frame buffer and channels.
// Depends on sxb_pkg, sxb_if, sxb_ram and sxb_pix.
//
//   port  dir  carries
//   req   in   draw one sprite row / read one display line
//   rsp   out  draw-done word with collision / 64-pixel line word
//   csr   in   clip_mode write, always ready
//
// Draw: fetch, load, 8 pixel steps through the shared pixel unit, write back,
// finish. Read: fetch, load, finish. A row off the bottom in clip mode: finish.
// Finish of a read or last draw row waits while the output register holds an
// untaken word. Reset clears the frame buffer at once via per-line valid bits.
module sprite_xor_blitter_core (
   input  logic      clock,
   input  logic      reset,
   sxb_req_if.sink   req,
   sxb_rsp_if.source rsp,
   sxb_csr_if.sink   csr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_LOAD,
      S_PIX,
      S_WRITE,
      S_DONE
   } state_type;

   state_type                              state_ff;
   logic                                   clip_ff;
   logic                                   collision_ff;
   logic [sxb_pkg::SCREEN_HEIGHT-1:0]      valid_ff;
   logic                                   rd_valid_ff;

   logic                                   cmd_ff;
   logic                                   last_ff;
   logic                                   in_range_ff;
   logic [sxb_pkg::Y_BITS-1:0]             y_ff;
   logic [sxb_pkg::X_BITS-1:0]             x0_ff;
   logic [sxb_pkg::ROW_BITS-1:0]           bits_ff;
   logic [sxb_pkg::STEP_BITS-1:0]          step_ff;
   logic [sxb_pkg::LINE_BITS-1:0]          line_ff;
   logic [sxb_pkg::LINE_BITS-1:0]          line_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_kind_ff;
   logic                                   rsp_collision_ff;
   logic [sxb_pkg::LINE_BITS-1:0]          rsp_pixels_ff;

   logic [sxb_pkg::YS_BITS-1:0]            y_sum;
   logic                                   y_over;
   logic                                   accept;
   logic                                   rsp_load;
   logic                                   pix_hit;
   logic [sxb_pkg::LINE_BITS-1:0]          rd_data;
   sxb_pkg::pix_ctl_type                   pix_ctl;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   assign rsp_load = (state_ff == S_DONE)
                     && !(cmd_ff == sxb_pkg::CMD_DRAW && !last_ff)
                     && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.collision  = rsp_collision_ff;
   assign rsp.row_pixels = rsp_pixels_ff;

   always_comb begin
      y_sum  = sxb_pkg::YS_BITS'(req.start_y[sxb_pkg::Y_BITS-1:0])
               + sxb_pkg::YS_BITS'(req.row_offset);
      y_over = (y_sum >= sxb_pkg::YS_BITS'(sxb_pkg::SCREEN_HEIGHT));
   end

   always_comb begin
      pix_ctl.x0     = x0_ff;
      pix_ctl.step   = step_ff;
      pix_ctl.bit_on = bits_ff[sxb_pkg::ROW_BITS-1];
      pix_ctl.clip   = clip_ff;
   end

   sxb_pix u_pix (
      .ctl      (pix_ctl),
      .line_cur (line_ff),
      .line_new (line_in),
      .hit      (pix_hit)
   );

   sxb_ram #(
      .WIDTH (sxb_pkg::LINE_BITS),
      .DEPTH (sxb_pkg::SCREEN_HEIGHT)
   ) u_fb (
      .clock   (clock),
      .wr_en   (state_ff == S_WRITE),
      .wr_addr (y_ff),
      .wr_data (line_ff),
      .rd_en   (state_ff == S_FETCH),
      .rd_addr (y_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clip_ff      <= 1'b1;
         collision_ff <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            clip_ff <= csr.clip_mode;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff  <= req.cmd;
                  last_ff <= req.last_row;
                  x0_ff   <= req.start_x[sxb_pkg::X_BITS-1:0];
                  bits_ff <= req.row_bits;
                  if (req.cmd == sxb_pkg::CMD_READ) begin
                     y_ff        <= sxb_pkg::Y_BITS'(req.display_row);
                     in_range_ff <= (32'(req.display_row) < sxb_pkg::SCREEN_HEIGHT);
                     state_ff    <= S_FETCH;
                  end else begin
                     y_ff        <= y_sum[sxb_pkg::Y_BITS-1:0];
                     in_range_ff <= 1'b1;
                     state_ff    <= (y_over && clip_ff) ? S_DONE : S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               rd_valid_ff <= valid_ff[y_ff];
               state_ff    <= S_LOAD;
            end
            S_LOAD: begin
               line_ff  <= (rd_valid_ff && in_range_ff) ? rd_data : '0;
               step_ff  <= '0;
               state_ff <= (cmd_ff == sxb_pkg::CMD_READ) ? S_DONE : S_PIX;
            end
            S_PIX: begin
               line_ff <= line_in;
               bits_ff <= bits_ff << 1;
               step_ff <= step_ff + sxb_pkg::STEP_BITS'(1);
               if (pix_hit) begin
                  collision_ff <= 1'b1;
               end
               if (step_ff == sxb_pkg::STEP_LAST) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               valid_ff[y_ff] <= 1'b1;
               state_ff       <= S_DONE;
            end
            S_DONE: begin
               if (cmd_ff == sxb_pkg::CMD_DRAW && !last_ff) begin
                  state_ff <= S_IDLE;
               end else if (rsp_load) begin
                  if (cmd_ff == sxb_pkg::CMD_READ) begin
                     rsp_kind_ff      <= sxb_pkg::KIND_READ;
                     rsp_collision_ff <= 1'b0;
                     rsp_pixels_ff    <= line_ff;
                  end else begin
                     rsp_kind_ff      <= sxb_pkg::KIND_DRAW;
                     rsp_collision_ff <= collision_ff;
                     rsp_pixels_ff    <= '0;
                     collision_ff     <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/sxb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sxb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sxb_pix.sv =====
// Shared pixel unit: places one sprite pixel on a display line by XOR.
// Depends on sxb_pkg for widths and the control struct.
module sxb_pix (
   input  sxb_pkg::pix_ctl_type            ctl,
   input  logic [sxb_pkg::LINE_BITS-1:0]   line_cur,
   output logic [sxb_pkg::LINE_BITS-1:0]   line_new,
   output logic                            hit
);

   logic [sxb_pkg::X_BITS:0]          col_sum;
   logic                              col_over;
   logic [sxb_pkg::LINE_IDX_BITS-1:0] bit_idx;
   logic                              active;
   logic [sxb_pkg::LINE_BITS-1:0]     mask;

   always_comb begin
      col_sum  = {1'b0, ctl.x0} + (sxb_pkg::X_BITS + 1)'(ctl.step);
      col_over = col_sum[sxb_pkg::X_BITS];
      bit_idx  = sxb_pkg::LINE_IDX_BITS'(sxb_pkg::LINE_BITS - 1)
                 - sxb_pkg::LINE_IDX_BITS'(col_sum[sxb_pkg::X_BITS-1:0]);
      active   = ctl.bit_on && !(col_over && ctl.clip);
      mask     = active ? (sxb_pkg::LINE_BITS'(1) << bit_idx) : '0;
      hit      = |(line_cur & mask);
      line_new = line_cur ^ mask;
   end

endmodule

// ===== rtl/sxb_check.sv =====
// Port-level checks of the sprite XOR blitter, bound to the top level.
// Depends on sxb_pkg and sprite_xor_blitter_core.
module sxb_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic                          rsp_collision,
   input logic [sxb_pkg::LINE_BITS-1:0] rsp_row_pixels
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held high after accepting a word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_collision) && $stable(rsp_row_pixels))
      else $error("stalled response word changed");

   a_read_no_collision: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sxb_pkg::KIND_READ |-> !rsp_collision)
      else $error("read word carries a collision");

   a_draw_no_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sxb_pkg::KIND_DRAW |-> rsp_row_pixels == '0)
      else $error("draw word carries pixels");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sprite_xor_blitter_core sxb_check u_sxb_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_kind       (rsp.kind),
   .rsp_collision  (rsp.collision),
   .rsp_row_pixels (rsp.row_pixels)
);
